// ===== design/palette_indexed_pixel_store_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for palette_indexed_pixel_store_top
// Clocked on clock, switched off while reset is high.
// ----------------------------------------------------------------------------
`ifndef PALETTE_INDEXED_PIXEL_STORE_TOP_ASSERT_SVH
`define PALETTE_INDEXED_PIXEL_STORE_TOP_ASSERT_SVH

// Condition holds at every edge.
`define PIS_ASSERT_HOLD(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("pis: invariant broken");

// Same-cycle implication.
`define PIS_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pis: implication broken");

// Next-cycle implication.
`define PIS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pis: follow-up broken");

`endif

// ===== design/pis_pkg.sv =====
// ----------------------------------------------------------------------------
// pis_pkg
// Shared constants, codes and types of the palette pixel store.
// ----------------------------------------------------------------------------
package pis_pkg;

   localparam int MAX_WIDTH       = 256;
   localparam int MAX_HEIGHT      = 256;
   localparam int PALETTE_ENTRIES = 255;

   localparam int XY_BITS       = 12;
   localparam int CHAN_BITS     = 16;
   localparam int RGBA_BITS     = 4 * CHAN_BITS;
   localparam int DIM_BITS      = 9;
   localparam int COL_BITS      = $clog2(MAX_WIDTH);
   localparam int ROW_BITS      = $clog2(MAX_HEIGHT);
   localparam int PIX_ADDR_BITS = COL_BITS + ROW_BITS;
   localparam int PIX_DEPTH     = MAX_WIDTH * MAX_HEIGHT;
   localparam int PAL_IDX_BITS  = 8;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   localparam logic FUNC_READ  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_MODE   = 2'd2;

   // Token walking the palette chain: a search key or a lookup index.
   typedef struct packed {
      logic                    valid;
      logic                    is_read;
      logic                    hit;
      logic [PAL_IDX_BITS-1:0] idx;
      logic [RGBA_BITS-1:0]    key;
   } token_type;

   // Palette append, broadcast to every cell.
   typedef struct packed {
      logic                    valid;
      logic [PAL_IDX_BITS-1:0] idx;
      logic [RGBA_BITS-1:0]    data;
   } pal_wr_type;

endpackage

// ===== design/palette_indexed_pixel_store_top.sv =====
// Out-of-range items and truecolour writes answer from idle, truecolour reads via the
// memory read state, palette writes via the 255-cell palette chain, palette reads via both.
// One item at a time; the next start is taken in the cycle its result shows.
// Reset is synchronous; afterwards a clearing pass zeroes the pixel memory with
// busy high. Configuration writes are taken throughout.
// The receiver cannot stall: each result is valid for exactly one cycle.
// ----------------------------------------------------------------------------
// palette_indexed_pixel_store_top
// Pixel framebuffer with optional exact-match colour palette.
// ----------------------------------------------------------------------------
`include "palette_indexed_pixel_store_top_assert.svh"

module palette_indexed_pixel_store_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_func,
   input  logic [pis_pkg::XY_BITS-1:0]       req_x_pos,
   input  logic [pis_pkg::XY_BITS-1:0]       req_y_pos,
   input  logic [pis_pkg::CHAN_BITS-1:0]     req_red,
   input  logic [pis_pkg::CHAN_BITS-1:0]     req_green,
   input  logic [pis_pkg::CHAN_BITS-1:0]     req_blue,
   input  logic [pis_pkg::CHAN_BITS-1:0]     req_alpha,
   output logic                              rsp_valid,
   output logic [pis_pkg::CHAN_BITS-1:0]     rsp_out_red,
   output logic [pis_pkg::CHAN_BITS-1:0]     rsp_out_green,
   output logic [pis_pkg::CHAN_BITS-1:0]     rsp_out_blue,
   output logic [pis_pkg::CHAN_BITS-1:0]     rsp_out_alpha,
   output logic [1:0]                        rsp_status,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [pis_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [pis_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [pis_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                              pready
);
   import pis_pkg::*;

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_MEMRD, ST_CHAIN} state_type;

   // configuration registers
   logic [DIM_BITS-1:0] width_ff;
   logic [DIM_BITS-1:0] height_ff;
   logic                mode_ff;
   logic [1:0]          csr_index;

   assign csr_index = paddr[3:2];
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= '0;
         height_ff <= '0;
         mode_ff   <= 1'b0;
      end else if (psel && penable && pwrite) begin
         case (csr_index)
            REG_WIDTH:  width_ff  <= pwdata[DIM_BITS-1:0];
            REG_HEIGHT: height_ff <= pwdata[DIM_BITS-1:0];
            REG_MODE:   mode_ff   <= pwdata[0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_WIDTH:  prdata = CSR_DATA_BITS'(width_ff);
         REG_HEIGHT: prdata = CSR_DATA_BITS'(height_ff);
         REG_MODE:   prdata = CSR_DATA_BITS'(mode_ff);
         default:    prdata = '0;
      endcase
   end

   // request decode
   state_type                state_ff;
   logic                     accept;
   logic                     in_range;
   logic [PIX_ADDR_BITS-1:0] req_addr;
   logic [RGBA_BITS-1:0]     req_rgba;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign in_range = (req_x_pos < XY_BITS'(width_ff)) && (req_x_pos < XY_BITS'(MAX_WIDTH)) &&
                     (req_y_pos < XY_BITS'(height_ff)) && (req_y_pos < XY_BITS'(MAX_HEIGHT));
   assign req_addr = {req_y_pos[ROW_BITS-1:0], req_x_pos[COL_BITS-1:0]};
   assign req_rgba = {req_red, req_green, req_blue, req_alpha};

   // item and status registers
   logic [PIX_ADDR_BITS-1:0] addr_ff;
   logic [PIX_ADDR_BITS-1:0] clr_addr_ff;
   logic [PAL_IDX_BITS-1:0]  pal_count_ff;
   logic                     rsp_valid_ff;
   logic [RGBA_BITS-1:0]     rsp_rgba_ff;
   logic [1:0]               rsp_status_ff;

   // pixel memory
   logic [RGBA_BITS-1:0]     pix_mem [PIX_DEPTH];
   logic [RGBA_BITS-1:0]     pix_rdata_ff;
   logic                     mem_we;
   logic [PIX_ADDR_BITS-1:0] mem_wa;
   logic [RGBA_BITS-1:0]     mem_wd;

   // palette chain
   token_type  chain_in;
   token_type  chain_out;
   pal_wr_type pal_wr;
   logic       pal_full;

   assign pal_full = (pal_count_ff == PAL_IDX_BITS'(PALETTE_ENTRIES));

   pis_chain u_chain (
      .clock   (clock),
      .reset   (reset),
      .count   (pal_count_ff),
      .wr      (pal_wr),
      .tok_in  (chain_in),
      .tok_out (chain_out)
   );

   always_comb begin
      chain_in         = '0;
      chain_in.key     = req_rgba;
      chain_in.is_read = 1'b0;
      if (state_ff == ST_IDLE) begin
         chain_in.valid = accept && in_range && (req_func == FUNC_WRITE) && mode_ff;
      end else if (state_ff == ST_MEMRD) begin
         // palette lookup of the stored index
         chain_in.valid   = mode_ff;
         chain_in.is_read = 1'b1;
         chain_in.idx     = pix_rdata_ff[PAL_IDX_BITS-1:0];
      end
   end

   always_comb begin
      mem_we      = 1'b0;
      mem_wa      = req_addr;
      mem_wd      = req_rgba;
      pal_wr      = '0;
      pal_wr.idx  = pal_count_ff;
      pal_wr.data = chain_out.key;
      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_addr_ff;
            mem_wd = '0;
         end
         ST_IDLE: begin
            mem_we = accept && in_range && (req_func == FUNC_WRITE) && !mode_ff;
         end
         ST_CHAIN: begin
            mem_wa = addr_ff;
            if (chain_out.valid && !chain_out.is_read) begin
               if (chain_out.hit) begin
                  mem_we = 1'b1;
                  mem_wd = RGBA_BITS'(chain_out.idx);
               end else if (!pal_full) begin
                  // append the colour at the next free index
                  mem_we       = 1'b1;
                  mem_wd       = RGBA_BITS'(pal_count_ff);
                  pal_wr.valid = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         pix_mem[mem_wa] <= mem_wd;
      end
      pix_rdata_ff <= pix_mem[req_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         pal_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
               if (clr_addr_ff == {PIX_ADDR_BITS{1'b1}}) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  addr_ff <= req_addr;
                  if (!in_range) begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_rgba_ff   <= '0;
                     rsp_status_ff <= STATUS_RANGE;
                  end else if (req_func == FUNC_READ) begin
                     state_ff <= ST_MEMRD;
                  end else if (mode_ff) begin
                     state_ff <= ST_CHAIN;
                  end else begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_rgba_ff   <= '0;
                     rsp_status_ff <= STATUS_OK;
                  end
               end
            end
            ST_MEMRD: begin
               if (mode_ff) begin
                  state_ff <= ST_CHAIN;
               end else begin
                  state_ff      <= ST_IDLE;
                  rsp_valid_ff  <= 1'b1;
                  rsp_rgba_ff   <= pix_rdata_ff;
                  rsp_status_ff <= STATUS_OK;
               end
            end
            ST_CHAIN: begin
               if (chain_out.valid) begin
                  state_ff      <= ST_IDLE;
                  rsp_valid_ff  <= 1'b1;
                  rsp_rgba_ff   <= '0;
                  rsp_status_ff <= STATUS_OK;
                  if (chain_out.is_read) begin
                     if (chain_out.idx < pal_count_ff) begin
                        rsp_rgba_ff <= chain_out.key;
                     end
                  end else if (!chain_out.hit) begin
                     if (pal_full) begin
                        rsp_status_ff <= STATUS_FULL;
                     end else begin
                        pal_count_ff <= pal_count_ff + 1'b1;
                     end
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = rsp_rgba_ff[4*CHAN_BITS-1:3*CHAN_BITS];
   assign rsp_out_green = rsp_rgba_ff[3*CHAN_BITS-1:2*CHAN_BITS];
   assign rsp_out_blue  = rsp_rgba_ff[2*CHAN_BITS-1:CHAN_BITS];
   assign rsp_out_alpha = rsp_rgba_ff[CHAN_BITS-1:0];
   assign rsp_status    = rsp_status_ff;

   `PIS_ASSERT_HOLD(a_count_bound, pal_count_ff <= PAL_IDX_BITS'(PALETTE_ENTRIES))
   `PIS_ASSERT_NEXT(a_range_beat, accept && !in_range, rsp_valid && rsp_status == STATUS_RANGE)
   `PIS_ASSERT_IMPL(a_chain_state, chain_out.valid, state_ff == ST_CHAIN)
   `PIS_ASSERT_IMPL(a_full_status, rsp_valid && rsp_status == STATUS_FULL, pal_full)

endmodule

// ===== design/pis_cell.sv =====
// ----------------------------------------------------------------------------
// pis_cell
// One palette entry: compares or supplies its colour to the passing token.
// ----------------------------------------------------------------------------
module pis_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [pis_pkg::PAL_IDX_BITS-1:0] cell_index,
   input  logic [pis_pkg::PAL_IDX_BITS-1:0] count,
   input  pis_pkg::pal_wr_type              wr,
   input  pis_pkg::token_type               tok_in,
   output pis_pkg::token_type               tok_out
);
   import pis_pkg::*;

   logic [RGBA_BITS-1:0] entry_ff;
   token_type            tok_out_ff;
   token_type            tok_out_in;

   always_comb begin
      tok_out_in = tok_in;
      if (tok_in.valid) begin
         if (tok_in.is_read) begin
            if (tok_in.idx == cell_index) begin
               tok_out_in.key = entry_ff;
            end
         end else if (!tok_in.hit && (cell_index < count) && (entry_ff == tok_in.key)) begin
            // first match wins: later cells see hit set
            tok_out_in.hit = 1'b1;
            tok_out_in.idx = cell_index;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_out_ff.valid <= 1'b0;
      end else begin
         tok_out_ff <= tok_out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.valid && (wr.idx == cell_index)) begin
         entry_ff <= wr.data;
      end
   end

   assign tok_out = tok_out_ff;

endmodule

// ===== design/pis_chain.sv =====
// ----------------------------------------------------------------------------
// pis_chain
// Row of palette cells; a token advances one cell per cycle.
// ----------------------------------------------------------------------------
module pis_chain (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [pis_pkg::PAL_IDX_BITS-1:0] count,
   input  pis_pkg::pal_wr_type              wr,
   input  pis_pkg::token_type               tok_in,
   output pis_pkg::token_type               tok_out
);
   import pis_pkg::*;

   token_type tok [PALETTE_ENTRIES+1];

   assign tok[0] = tok_in;

   for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_cell
      pis_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (PAL_IDX_BITS'(i)),
         .count      (count),
         .wr         (wr),
         .tok_in     (tok[i]),
         .tok_out    (tok[i+1])
      );
   end

   assign tok_out = tok[PALETTE_ENTRIES];

endmodule

// ===== tb/pixel_store_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_store_checker
// Watches the request, reply and register ports of the pixel store, keeps its
// own copy of the pixel memory, palette and settings, and compares every reply
// beat field by field with the oldest predicted reply.
// ----------------------------------------------------------------------------
module pixel_store_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic                              req_func,
   input  logic [pis_pkg::XY_BITS-1:0]       req_x_pos,
   input  logic [pis_pkg::XY_BITS-1:0]       req_y_pos,
   input  logic [pis_pkg::CHAN_BITS-1:0]     req_red,
   input  logic [pis_pkg::CHAN_BITS-1:0]     req_green,
   input  logic [pis_pkg::CHAN_BITS-1:0]     req_blue,
   input  logic [pis_pkg::CHAN_BITS-1:0]     req_alpha,
   input  logic                              rsp_valid,
   input  logic [pis_pkg::CHAN_BITS-1:0]     rsp_out_red,
   input  logic [pis_pkg::CHAN_BITS-1:0]     rsp_out_green,
   input  logic [pis_pkg::CHAN_BITS-1:0]     rsp_out_blue,
   input  logic [pis_pkg::CHAN_BITS-1:0]     rsp_out_alpha,
   input  logic [1:0]                        rsp_status,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [pis_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [pis_pkg::CSR_DATA_BITS-1:0] pwdata,
   input  logic                              pready,
   output int                                error_count,
   output int                                outstanding,
   output logic [pis_pkg::PAL_IDX_BITS-1:0]  palette_used
);
   import pis_pkg::*;

   typedef struct packed {
      logic [CHAN_BITS-1:0] red;
      logic [CHAN_BITS-1:0] green;
      logic [CHAN_BITS-1:0] blue;
      logic [CHAN_BITS-1:0] alpha;
      logic [1:0]           status;
   } pixel_reply_type;

   bit [RGBA_BITS-1:0]    pixel_mem [PIX_DEPTH];
   bit [RGBA_BITS-1:0]    palette_mem [PALETTE_ENTRIES];
   bit [PAL_IDX_BITS-1:0] palette_fill;
   bit [DIM_BITS-1:0]     cfg_width;
   bit [DIM_BITS-1:0]     cfg_height;
   bit                    cfg_mode;
   pixel_reply_type       pixel_replies [$];
   int                    reply_count;

   task automatic flag_error(input string msg);
      error_count++;
      $display("checker: reply %0d: %s", reply_count, msg);
   endtask

   // Apply one access to the copy of the store and return the reply it earns.
   function automatic pixel_reply_type apply_pixel_access(input logic func,
                                                         input logic [XY_BITS-1:0] x,
                                                         input logic [XY_BITS-1:0] y,
                                                         input logic [RGBA_BITS-1:0] colour);
      pixel_reply_type    reply;
      bit [RGBA_BITS-1:0] word;
      int                 addr;
      reply = '0;
      if (x >= cfg_width || x >= MAX_WIDTH || y >= cfg_height || y >= MAX_HEIGHT) begin
         reply.status = STATUS_RANGE;
         return reply;
      end
      addr = int'(y) * MAX_WIDTH + int'(x);
      if (func == FUNC_READ) begin
         word = pixel_mem[addr];
         if (cfg_mode) begin
            word = (word[PAL_IDX_BITS-1:0] < palette_fill) ?
                   palette_mem[word[PAL_IDX_BITS-1:0]] : '0;
         end
         reply.red   = word[63:48];
         reply.green = word[47:32];
         reply.blue  = word[31:16];
         reply.alpha = word[15:0];
         return reply;
      end
      if (!cfg_mode) begin
         pixel_mem[addr] = colour;
         return reply;
      end
      // first exact match wins
      for (int slot = 0; slot < int'(palette_fill); slot++) begin
         if (palette_mem[slot] == colour) begin
            pixel_mem[addr] = 64'(slot);
            return reply;
         end
      end
      if (palette_fill == PALETTE_ENTRIES) begin
         reply.status = STATUS_FULL;
         return reply;
      end
      palette_mem[palette_fill] = colour;
      pixel_mem[addr] = 64'(palette_fill);
      palette_fill++;
      return reply;
   endfunction

   always @(posedge clock) begin
      pixel_reply_type got;
      pixel_reply_type want;
      pixel_reply_type pred;
      if (reset) begin
         for (int i = 0; i < PIX_DEPTH; i++) pixel_mem[i] = '0;
         for (int i = 0; i < PALETTE_ENTRIES; i++) palette_mem[i] = '0;
         palette_fill = '0;
         cfg_width    = '0;
         cfg_height   = '0;
         cfg_mode     = 1'b0;
         pixel_replies.delete();
         reply_count  = 0;
         error_count  = 0;
      end else begin
         if (rsp_valid) begin
            got = {rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha, rsp_status};
            if (pixel_replies.size() == 0) begin
               flag_error("reply beat with nothing pending");
            end else begin
               want = pixel_replies.pop_front();
               if (got.red !== want.red)
                  flag_error($sformatf("red %h, want %h", got.red, want.red));
               if (got.green !== want.green)
                  flag_error($sformatf("green %h, want %h", got.green, want.green));
               if (got.blue !== want.blue)
                  flag_error($sformatf("blue %h, want %h", got.blue, want.blue));
               if (got.alpha !== want.alpha)
                  flag_error($sformatf("alpha %h, want %h", got.alpha, want.alpha));
               if (got.status !== want.status)
                  flag_error($sformatf("status %0d, want %0d", got.status, want.status));
            end
            reply_count++;
         end
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               REG_WIDTH:  cfg_width  = pwdata[DIM_BITS-1:0];
               REG_HEIGHT: cfg_height = pwdata[DIM_BITS-1:0];
               REG_MODE:   cfg_mode   = pwdata[0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            pred = apply_pixel_access(req_func, req_x_pos, req_y_pos,
                                      {req_red, req_green, req_blue, req_alpha});
            pixel_replies.insert(pixel_replies.size(), pred);
         end
      end
      outstanding  = pixel_replies.size();
      palette_used = palette_fill;
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Directed and random pixel reads and writes in truecolour and palette mode,
// over a range of image sizes, with random request gaps; replies are checked
// by pixel_store_checker.
// ----------------------------------------------------------------------------
module testbench;
   import pis_pkg::*;

   localparam int         RUN_LIMIT   = 2_000_000;
   localparam int         TAIL_CYCLES = 300;
   // tag of a pixel holding a palette index, always a valid entry
   localparam bit [8:0]   PAL_SAFE    = 9'h100;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic                     req_func;
   logic [XY_BITS-1:0]       req_x_pos;
   logic [XY_BITS-1:0]       req_y_pos;
   logic [CHAN_BITS-1:0]     req_red;
   logic [CHAN_BITS-1:0]     req_green;
   logic [CHAN_BITS-1:0]     req_blue;
   logic [CHAN_BITS-1:0]     req_alpha;
   logic                     rsp_valid;
   logic [CHAN_BITS-1:0]     rsp_out_red;
   logic [CHAN_BITS-1:0]     rsp_out_green;
   logic [CHAN_BITS-1:0]     rsp_out_blue;
   logic [CHAN_BITS-1:0]     rsp_out_alpha;
   logic [1:0]               rsp_status;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   int                       check_errors;
   int                       replies_due;
   logic [PAL_IDX_BITS-1:0]  palette_used;
   int                       cycle_count;

   int                       cfg_width;
   int                       cfg_height;
   bit                       cfg_mode;
   // low byte of each stored truecolour word, or PAL_SAFE
   bit [8:0]                 pixel_tag [PIX_DEPTH];
   logic [RGBA_BITS-1:0]     colour_pool [8];

   palette_indexed_pixel_store_top u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_func      (req_func),
      .req_x_pos     (req_x_pos),
      .req_y_pos     (req_y_pos),
      .req_red       (req_red),
      .req_green     (req_green),
      .req_blue      (req_blue),
      .req_alpha     (req_alpha),
      .rsp_valid     (rsp_valid),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_out_alpha (rsp_out_alpha),
      .rsp_status    (rsp_status),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   pixel_store_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_func      (req_func),
      .req_x_pos     (req_x_pos),
      .req_y_pos     (req_y_pos),
      .req_red       (req_red),
      .req_green     (req_green),
      .req_blue      (req_blue),
      .req_alpha     (req_alpha),
      .rsp_valid     (rsp_valid),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_out_alpha (rsp_out_alpha),
      .rsp_status    (rsp_status),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .pready        (pready),
      .error_count   (check_errors),
      .outstanding   (replies_due),
      .palette_used  (palette_used)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // Present one request beat at a falling edge and hold it until taken.
   task automatic send_access(input logic func, input logic [XY_BITS-1:0] x,
                              input logic [XY_BITS-1:0] y,
                              input logic [RGBA_BITS-1:0] colour);
      logic                    op;
      bit                      in_range;
      int                      addr;
      logic [PAL_IDX_BITS-1:0] fill_before;
      op          = func;
      in_range    = (x < cfg_width) && (y < cfg_height);
      addr        = in_range ? int'(y) * MAX_WIDTH + int'(x) : 0;
      fill_before = palette_used;
      // turn a palette read of a never-written entry into a write
      if (op == FUNC_READ && in_range && cfg_mode && !pixel_tag[addr][8] &&
          pixel_tag[addr][7:0] >= fill_before)
         op = FUNC_WRITE;
      start     <= 1'b1;
      req_func  <= op;
      req_x_pos <= x;
      req_y_pos <= y;
      req_red   <= colour[63:48];
      req_green <= colour[47:32];
      req_blue  <= colour[31:16];
      req_alpha <= colour[15:0];
      do @(posedge clock); while (busy);
      if (op == FUNC_WRITE && in_range) begin
         if (!cfg_mode)
            pixel_tag[addr] = {1'b0, colour[7:0]};
         else if (fill_before < PALETTE_ENTRIES)
            pixel_tag[addr] = PAL_SAFE;
      end
      @(negedge clock);
   endtask

   // Drop start and wait until every reply has come back.
   task automatic settle();
      start <= 1'b0;
      while (replies_due != 0 || busy) @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input int unsigned value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      case (idx)
         REG_WIDTH:  cfg_width  = int'(value & 32'h1FF);
         REG_HEIGHT: cfg_height = int'(value & 32'h1FF);
         REG_MODE:   cfg_mode   = value[0];
         default: ;
      endcase
   endtask

   task automatic run_phase(input int w, input int h, input bit mode, input int items,
                            input int write_pct, input int fresh_pct, input int gap_pct);
      logic                 func;
      logic [XY_BITS-1:0]   x;
      logic [XY_BITS-1:0]   y;
      logic [RGBA_BITS-1:0] colour;
      int                   sel;
      settle();
      write_csr(REG_WIDTH, w);
      write_csr(REG_HEIGHT, h);
      write_csr(REG_MODE, 32'(mode));
      for (int n = 0; n < items; n++) begin
         if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
         end
         func = ($urandom_range(0, 99) < write_pct) ? FUNC_WRITE : FUNC_READ;
         sel  = $urandom_range(0, 99);
         if (sel < 15 || cfg_width == 0 || cfg_height == 0) begin
            x = 12'($urandom_range(0, 4095));
            y = 12'($urandom_range(0, 4095));
         end else if (sel < 60) begin
            // small corner, so reads land on written pixels
            x = 12'($urandom_range(0, (cfg_width < 8 ? cfg_width : 8) - 1));
            y = 12'($urandom_range(0, (cfg_height < 8 ? cfg_height : 8) - 1));
         end else begin
            x = 12'($urandom_range(0, cfg_width - 1));
            y = 12'($urandom_range(0, cfg_height - 1));
         end
         colour = ($urandom_range(0, 99) < fresh_pct) ? {$urandom, $urandom} :
                  colour_pool[$urandom_range(0, 7)];
         send_access(func, x, y, colour);
      end
   endtask

   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_func  = FUNC_READ;
      req_x_pos = '0;
      req_y_pos = '0;
      req_red   = '0;
      req_green = '0;
      req_blue  = '0;
      req_alpha = '0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      colour_pool[0] = '1;
      colour_pool[1] = '0;
      for (int i = 2; i < 8; i++) colour_pool[i] = {$urandom, $urandom};
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // zero-sized image after reset: everything is out of range
      send_access(FUNC_READ, 12'd0, 12'd0, '0);
      send_access(FUNC_WRITE, 12'd0, 12'd0, '1);
      settle();
      write_csr(REG_WIDTH, 256);
      write_csr(REG_HEIGHT, 256);
      write_csr(REG_MODE, 0);
      send_access(FUNC_WRITE, 12'd0, 12'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_access(FUNC_READ, 12'd0, 12'd0, '0);
      send_access(FUNC_WRITE, 12'd255, 12'd255, 64'h8000_8000_8000_8000);
      send_access(FUNC_READ, 12'd255, 12'd255, '0);
      send_access(FUNC_WRITE, 12'd255, 12'd0, 64'hAAAA_5555_1234_0001);
      send_access(FUNC_READ, 12'd256, 12'd0, '0);
      send_access(FUNC_READ, 12'd0, 12'd4095, '0);
      send_access(FUNC_WRITE, 12'd4095, 12'd4095, 64'h5A5A_A5A5_0F0F_F0F0);
      send_access(FUNC_READ, 12'd7, 12'd7, '0);
      settle();
      write_csr(REG_MODE, 1);
      // append two colours, then hit the first
      send_access(FUNC_WRITE, 12'd1, 12'd1, 64'h0123_4567_89AB_CDEF);
      send_access(FUNC_WRITE, 12'd2, 12'd1, 64'hFEDC_BA98_7654_3210);
      send_access(FUNC_WRITE, 12'd3, 12'd1, 64'h0123_4567_89AB_CDEF);
      send_access(FUNC_READ, 12'd1, 12'd1, '0);
      send_access(FUNC_READ, 12'd2, 12'd1, '0);
      send_access(FUNC_READ, 12'd3, 12'd1, '0);
      // truecolour words read as palette indices
      send_access(FUNC_READ, 12'd255, 12'd0, '0);
      send_access(FUNC_READ, 12'd7, 12'd7, '0);
      settle();
      write_csr(REG_MODE, 0);
      // palette indices read as truecolour
      send_access(FUNC_READ, 12'd1, 12'd1, '0);
      send_access(FUNC_READ, 12'd2, 12'd1, '0);

      run_phase(256, 256, 1'b0, 150, 50, 60, 20);
      run_phase(256, 256, 1'b1, 150, 55, 15, 20);
      run_phase(1, 1, 1'b0, 40, 50, 50, 0);
      // mostly fresh colours: fill the palette and run past full
      run_phase(256, 256, 1'b1, 330, 85, 90, 10);
      run_phase(0, 256, 1'b1, 30, 50, 50, 30);
      run_phase(256, 0, 1'b0, 30, 50, 50, 30);
      run_phase($urandom_range(1, 256), $urandom_range(1, 256), 1'b0, 150, 50, 50, 25);
      run_phase($urandom_range(1, 256), $urandom_range(1, 256), 1'b1, 150, 50, 20, 25);
      run_phase(256, 256, 1'b0, 100, 40, 50, 0);
      run_phase(256, 256, 1'b1, 150, 50, 20, 0);

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (check_errors == 0 && replies_due == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule
